[hw/rtl/row_rank_transform_top_defines.svh]
// ----------------------------------------------------------------------------
// row_rank_transform_top_defines
// Assertion macros used by the row rank transform controller (rrt_ctrl).
// ----------------------------------------------------------------------------
`ifndef ROW_RANK_TRANSFORM_TOP_DEFINES_SVH
`define ROW_RANK_TRANSFORM_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Check a property on every clock edge out of reset.
`define RRT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Check that a condition implies a consequence in the next cycle.
`define RRT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RRT_ASSERT(lbl, prop, msg)
`define RRT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

[hw/rtl/rrt_pkg.sv]
// ----------------------------------------------------------------------------
// rrt_pkg
// Types and constants of the row rank transform.
// ----------------------------------------------------------------------------
`default_nettype none

package rrt_pkg;

  localparam int SAMPLE_W = 32;
  localparam int RANK_W   = 7;

  typedef enum logic [1:0] {
    ST_FILL,
    ST_RANK,
    ST_DRAIN
  } rrt_state_e;

  typedef struct packed {
    logic load;
    logic step;
    logic drain;
    logic asc;
  } cell_ctrl_t;

endpackage

`default_nettype wire

[hw/rtl/row_rank_transform_top.sv]
// ----------------------------------------------------------------------------
// row_rank_transform_top
// Ordinal rank transform of a row of signed values.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i/in_ready_o): one sample per transaction, row_end_i
// on the last sample of a row. Samples of a row are taken one per cycle and
// written into a chain of ROW_CAPACITY cells; samples beyond capacity are
// dropped and flag the row. After the row-end transaction the chain runs a
// rank pass: each cell's key circulates around the ring once and every cell
// counts the keys that rank ahead of its own. Output channel
// (out_valid_o/out_ready_i): one rank per stored column, in column order,
// shifted out of the chain one per cycle; run_end_o marks the last column
// and overflow_flag_o marks a row that lost samples. The first rank is
// presented once the rank pass ends. Input is held off from the row end
// until the last rank is taken; a stalled receiver simply holds the current
// rank. Configuration (cfg_valid_i/cfg_ready_o) selects ascending order
// (reset value 1) and is always ready. Reset clears the row and returns the
// block to accepting samples.
// ----------------------------------------------------------------------------
`default_nettype none

module row_rank_transform_top import rrt_pkg::*; #(
  parameter int ROW_CAPACITY = 64,
  parameter int VALUE_WIDTH  = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [SAMPLE_W-1:0] sample_value_i,
  input  logic                row_end_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [RANK_W-1:0]   rank_value_o,
  output logic                run_end_o,
  output logic                overflow_flag_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic                ascending_order_i
);

  localparam int KEY_W  = (VALUE_WIDTH < SAMPLE_W) ? VALUE_WIDTH : SAMPLE_W;
  localparam int IDX_W  = $clog2(ROW_CAPACITY);
  localparam int CNT1_W = $clog2(ROW_CAPACITY + 1);

  cell_ctrl_t              cell_ctrl;
  logic                    wr_en;
  logic [IDX_W-1:0]        wr_idx;
  logic [CNT1_W-1:0]       elem_cnt;
  logic signed [KEY_W-1:0] wr_key;

  logic signed [KEY_W-1:0] key      [ROW_CAPACITY];
  logic signed [KEY_W-1:0] probe_key[ROW_CAPACITY];
  logic [IDX_W-1:0]        probe_idx[ROW_CAPACITY];
  logic                    probe_vld[ROW_CAPACITY];
  logic [IDX_W-1:0]        cnt      [ROW_CAPACITY];

  assign wr_key = sample_value_i[KEY_W-1:0];

  rrt_ctrl #(
    .ROW_CAPACITY(ROW_CAPACITY)
  ) u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .row_end_i        (row_end_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .run_end_o        (run_end_o),
    .overflow_flag_o  (overflow_flag_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .ascending_order_i(ascending_order_i),
    .wr_en_o          (wr_en),
    .wr_idx_o         (wr_idx),
    .elem_cnt_o       (elem_cnt),
    .cell_ctrl_o      (cell_ctrl)
  );

  for (genvar i = 0; i < ROW_CAPACITY; i++) begin : g_cell
    localparam int NB = (i + 1) % ROW_CAPACITY;
    localparam logic [IDX_W-1:0] CellIdx = IDX_W'(i);

    rrt_cell #(
      .ROW_CAPACITY(ROW_CAPACITY),
      .KEY_W       (KEY_W),
      .CELL_IDX    (i)
    ) u_cell (
      .clk_i          (clk_i),
      .rst_ni         (rst_ni),
      .ctrl_i         (cell_ctrl),
      .wr_en_i        (wr_en && (wr_idx == CellIdx)),
      .wr_key_i       (wr_key),
      .elem_cnt_i     (elem_cnt),
      .nbr_key_i      (key[NB]),
      .nbr_probe_key_i(probe_key[NB]),
      .nbr_probe_idx_i(probe_idx[NB]),
      .nbr_probe_vld_i(probe_vld[NB]),
      .nbr_cnt_i      (cnt[NB]),
      .key_o          (key[i]),
      .probe_key_o    (probe_key[i]),
      .probe_idx_o    (probe_idx[i]),
      .probe_vld_o    (probe_vld[i]),
      .cnt_o          (cnt[i])
    );
  end

  assign rank_value_o = RANK_W'(cnt[0]) + RANK_W'(1);

endmodule

`default_nettype wire

[hw/rtl/rrt_cell.sv]
// ----------------------------------------------------------------------------
// rrt_cell
// One column of the rank chain: stored key, circulating probe, rank count.
// ----------------------------------------------------------------------------
`default_nettype none

module rrt_cell import rrt_pkg::*; #(
  parameter int ROW_CAPACITY = 64,
  parameter int KEY_W        = 32,
  parameter int CELL_IDX     = 0
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  cell_ctrl_t                            ctrl_i,
  input  logic                                  wr_en_i,
  input  logic signed [KEY_W-1:0]               wr_key_i,
  input  logic [$clog2(ROW_CAPACITY+1)-1:0]     elem_cnt_i,
  input  logic signed [KEY_W-1:0]               nbr_key_i,
  input  logic signed [KEY_W-1:0]               nbr_probe_key_i,
  input  logic [$clog2(ROW_CAPACITY)-1:0]       nbr_probe_idx_i,
  input  logic                                  nbr_probe_vld_i,
  input  logic [$clog2(ROW_CAPACITY)-1:0]       nbr_cnt_i,
  output logic signed [KEY_W-1:0]               key_o,
  output logic signed [KEY_W-1:0]               probe_key_o,
  output logic [$clog2(ROW_CAPACITY)-1:0]       probe_idx_o,
  output logic                                  probe_vld_o,
  output logic [$clog2(ROW_CAPACITY)-1:0]       cnt_o
);

  localparam int IDX_W  = $clog2(ROW_CAPACITY);
  localparam int CNT1_W = $clog2(ROW_CAPACITY + 1);
  localparam int NEXT   = (CELL_IDX + 1) % ROW_CAPACITY;
  localparam logic [IDX_W-1:0]  SelfIdx = IDX_W'(CELL_IDX);
  localparam logic [IDX_W-1:0]  NextIdx = IDX_W'(NEXT);
  localparam logic [CNT1_W-1:0] NextCnt = CNT1_W'(NEXT);

  logic signed [KEY_W-1:0] key_q;
  logic signed [KEY_W-1:0] probe_key_q, probe_key_d;
  logic [IDX_W-1:0]        probe_idx_q, probe_idx_d;
  logic                    probe_vld_q, probe_vld_d;
  logic [IDX_W-1:0]        cnt_q, cnt_d;
  logic                    hit;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      key_q <= wr_key_i;
    end
  end

  always_comb begin
    if (probe_key_q == key_q) begin
      hit = probe_idx_q < SelfIdx;
    end else if (ctrl_i.asc) begin
      hit = probe_key_q < key_q;
    end else begin
      hit = probe_key_q > key_q;
    end
    hit = hit && probe_vld_q;
  end

  always_comb begin
    probe_key_d = probe_key_q;
    probe_idx_d = probe_idx_q;
    probe_vld_d = probe_vld_q;
    cnt_d       = cnt_q;
    if (ctrl_i.load) begin
      probe_key_d = nbr_key_i;
      probe_idx_d = NextIdx;
      probe_vld_d = NextCnt < elem_cnt_i;
      cnt_d       = '0;
    end else if (ctrl_i.step) begin
      probe_key_d = nbr_probe_key_i;
      probe_idx_d = nbr_probe_idx_i;
      probe_vld_d = nbr_probe_vld_i;
      cnt_d       = cnt_q + IDX_W'(hit);
    end else if (ctrl_i.drain) begin
      cnt_d = nbr_cnt_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      probe_vld_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      probe_vld_q <= probe_vld_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    probe_key_q <= probe_key_d;
    probe_idx_q <= probe_idx_d;
  end

  assign key_o       = key_q;
  assign probe_key_o = probe_key_q;
  assign probe_idx_o = probe_idx_q;
  assign probe_vld_o = probe_vld_q;
  assign cnt_o       = cnt_q;

endmodule

`default_nettype wire

[hw/rtl/rrt_ctrl.sv]
// ----------------------------------------------------------------------------
// rrt_ctrl
// Row sequencer: fill, rank pass and drain, plus the order register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "row_rank_transform_top_defines.svh"

module rrt_ctrl import rrt_pkg::*; #(
  parameter int ROW_CAPACITY = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              row_end_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              run_end_o,
  output logic                              overflow_flag_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic                              ascending_order_i,
  output logic                              wr_en_o,
  output logic [$clog2(ROW_CAPACITY)-1:0]   wr_idx_o,
  output logic [$clog2(ROW_CAPACITY+1)-1:0] elem_cnt_o,
  output cell_ctrl_t                        cell_ctrl_o
);

  localparam int IDX_W  = $clog2(ROW_CAPACITY);
  localparam int CNT1_W = $clog2(ROW_CAPACITY + 1);
  localparam logic [CNT1_W-1:0] CapCnt   = CNT1_W'(ROW_CAPACITY);
  localparam logic [IDX_W-1:0]  LastStep = IDX_W'(ROW_CAPACITY - 1);

  rrt_state_e         state_q, state_d;
  logic [CNT1_W-1:0]  elem_cnt_q, elem_cnt_d;
  logic               dropped_q, dropped_d;
  logic               asc_q;
  logic [IDX_W-1:0]   step_q, step_d;
  logic [IDX_W-1:0]   col_q, col_d;
  logic               in_fire, out_fire, full, last_col, rank_done;

  assign full      = elem_cnt_q == CapCnt;
  assign in_fire   = in_valid_i && in_ready_o;
  assign out_fire  = out_valid_o && out_ready_i;
  assign last_col  = (CNT1_W'(col_q) + CNT1_W'(1)) == elem_cnt_q;
  assign rank_done = step_q == LastStep;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_FILL: begin
        if (in_fire && row_end_i) begin
          state_d = ST_RANK;
        end
      end
      ST_RANK: begin
        if (rank_done) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (out_fire && last_col) begin
          state_d = ST_FILL;
        end
      end
      default: state_d = ST_FILL;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o        = 1'b0;
    out_valid_o       = 1'b0;
    cell_ctrl_o.load  = 1'b0;
    cell_ctrl_o.step  = 1'b0;
    cell_ctrl_o.drain = 1'b0;
    case (state_q)
      ST_FILL:  in_ready_o = 1'b1;
      ST_RANK: begin
        cell_ctrl_o.load = step_q == '0;
        cell_ctrl_o.step = step_q != '0;
      end
      ST_DRAIN: begin
        out_valid_o       = 1'b1;
        cell_ctrl_o.drain = out_ready_i;
      end
      default: in_ready_o = 1'b0;
    endcase
    cell_ctrl_o.asc = asc_q;
  end

  always_comb begin
    elem_cnt_d = elem_cnt_q;
    dropped_d  = dropped_q;
    step_d     = step_q;
    col_d      = col_q;
    if (in_fire) begin
      if (full) begin
        dropped_d = 1'b1;
      end else begin
        elem_cnt_d = elem_cnt_q + CNT1_W'(1);
      end
      step_d = '0;
      col_d  = '0;
    end
    if (state_q == ST_RANK) begin
      step_d = step_q + IDX_W'(1);
    end
    if (out_fire) begin
      col_d = col_q + IDX_W'(1);
      if (last_col) begin
        elem_cnt_d = '0;
        dropped_d  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_FILL;
      elem_cnt_q <= '0;
      dropped_q  <= 1'b0;
      asc_q      <= 1'b1;
      step_q     <= '0;
      col_q      <= '0;
    end else begin
      state_q    <= state_d;
      elem_cnt_q <= elem_cnt_d;
      dropped_q  <= dropped_d;
      step_q     <= step_d;
      col_q      <= col_d;
      if (cfg_valid_i && cfg_ready_o) begin
        asc_q <= ascending_order_i;
      end
    end
  end

  assign cfg_ready_o     = 1'b1;
  assign wr_en_o         = in_fire && !full;
  assign wr_idx_o        = elem_cnt_q[IDX_W-1:0];
  assign elem_cnt_o      = elem_cnt_q;
  assign run_end_o       = last_col;
  assign overflow_flag_o = dropped_q;

  `RRT_ASSERT(a_no_overlap, !(in_ready_o && out_valid_o), "input and output phases overlap")
  `RRT_ASSERT(a_cnt_bound, elem_cnt_q <= CapCnt, "element count beyond row capacity")
  `RRT_ASSERT(a_drain_nonempty, !out_valid_o || (elem_cnt_q != '0), "drain with empty row")
  `RRT_ASSERT_NEXT(a_rank_len, (state_q == ST_RANK) && rank_done, state_q == ST_DRAIN,
                   "rank pass did not end on time")
  `RRT_ASSERT_NEXT(a_row_close, out_fire && last_col, in_ready_o && (elem_cnt_q == '0),
                   "row not closed after last result")

endmodule

`default_nettype wire
